FILE: hdl/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform core.
// Used by the top level, the port checker and the testbench.
package hpt_pkg;

    // Action codes of a request.
    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_POINT  = 3'd1;
    localparam logic [2:0] ACT_VECTOR = 3'd2;
    localparam logic [2:0] ACT_NORMAL = 3'd3;
    localparam logic [2:0] ACT_BOX    = 3'd4;

    // Matrix word store: forward matrix first, inverse matrix after it.
    localparam int WORDS        = 32;
    localparam int INVERSE_BASE = 16;

    // Quotient bits resolved in each divider stage.
    localparam int DIV_BITS = 2;

    // Input request.
    typedef struct packed {
        logic [2:0]          action;
        logic [4:0]          entry_index;
        logic signed [31:0]  entry_value;
        logic signed [31:0]  first_x;
        logic signed [31:0]  first_y;
        logic signed [31:0]  first_z;
        logic signed [31:0]  second_x;
        logic signed [31:0]  second_y;
        logic signed [31:0]  second_z;
    } t_in;

    // Result request.
    typedef struct packed {
        logic signed [31:0]  lo_x;
        logic signed [31:0]  lo_y;
        logic signed [31:0]  lo_z;
        logic signed [31:0]  hi_x;
        logic signed [31:0]  hi_y;
        logic signed [31:0]  hi_z;
        logic                overflow;
    } t_out;

    // Control that travels with one transform pass.
    typedef struct packed {
        logic is_div;
        logic is_box;
        logic first;
        logic last;
    } t_ctl;

    // Sideband that travels beside the divider lanes.
    typedef struct packed {
        logic             vld;
        logic             use_div;
        logic [2:0]       neg;
        logic [2:0][31:0] val;
        logic             ov;
        t_ctl             ctl;
    } t_side;

endpackage

FILE: hdl/hpt_divider.sv
// Pipelined unsigned restoring divider, a fixed number of quotient bits per stage.
// Depends on nothing but its parameters; the divisor is at most 2^31.
module hpt_divider #(
    parameter int DW  = 48,
    parameter int BPS = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic [DW-1:0] o_quotient
);

    localparam int NSTG = (DW + BPS - 1) / BPS;
    localparam int PW   = NSTG * BPS;

    logic [31:0]   r_rem [NSTG];
    logic [31:0]   r_dvs [NSTG];
    logic [PW-1:0] r_num [NSTG];
    logic [PW-1:0] r_quo [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [31:0]   n_rem;
        logic [31:0]   n_dvs;
        logic [PW-1:0] n_num;
        logic [PW-1:0] n_quo;

        // Resolve this stage's quotient bits, most significant first.
        // Padding bits above the dividend only give leading zero quotient bits.
        always_comb begin
            logic [32:0] trial;
            if (s == 0) begin
                n_rem = '0;
                n_dvs = i_divisor;
                n_num = PW'(i_dividend);
                n_quo = '0;
            end else begin
                n_rem = r_rem[s-1];
                n_dvs = r_dvs[s-1];
                n_num = r_num[s-1];
                n_quo = r_quo[s-1];
            end
            for (int b = 0; b < BPS; b++) begin
                trial = {n_rem, n_num[PW-1]};
                n_num = n_num << 1;
                if (trial >= {1'b0, n_dvs}) begin
                    n_rem = 32'(trial - {1'b0, n_dvs});
                    n_quo = {n_quo[PW-2:0], 1'b1};
                end else begin
                    n_rem = trial[31:0];
                    n_quo = {n_quo[PW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dvs[s] <= n_dvs;
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_quotient = r_quo[NSTG-1][DW-1:0];

endmodule

FILE: hdl/homogeneous_point_transform_core.sv
// Top level of the homogeneous 4x4 point transform core.
// Depends on hpt_pkg and hpt_divider.
//
// Usage:
// Requests enter on i_valid/o_stall with payload i_data; results leave on
// o_valid/i_stall with payload o_data. A load request writes one matrix word
// (0-15 forward, 16-31 inverse, row-major) and gives no result; it takes
// effect for every request accepted after it. Actions 5 to 7 are dropped.
// Point, vector and normal requests take one pass through the pipeline and
// a box request takes eight passes, one per corner. So the input accepts one
// request per cycle for points, vectors and normals while the pipeline
// moves, and a box holds the input until its last corner is issued. All
// passes travel through the two-bit-per-stage divider; a box result appears
// when its last corner has gone through. Reset loads the identity into both
// matrices and empties the pipeline. When the receiver stalls a shown
// result, the whole pipeline holds and the input stalls once the issue
// register is occupied; nothing is lost.
module homogeneous_point_transform_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hpt_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output hpt_pkg::t_out o_data
);

    localparam int DW   = 32 + FRACTION_BITS;
    localparam int AW   = 65 - FRACTION_BITS;
    localparam int NSTG = (DW + hpt_pkg::DIV_BITS - 1) / hpt_pkg::DIV_BITS;

    localparam logic [31:0]          ONE32 = 32'(64'd1 << FRACTION_BITS);
    localparam logic signed [AW-1:0] ONE   = AW'(64'd1 << FRACTION_BITS);
    localparam logic signed [AW-1:0] SMAX  = AW'(64'sh7FFF_FFFF);
    localparam logic signed [AW-1:0] SMIN  = AW'(-64'sh8000_0000);
    localparam logic [31:0]          MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0]          MIN32 = 32'h8000_0000;

    // Saturate a wide sum to 32 bits; the top bit reports saturation.
    function automatic logic [32:0] sat32(input logic signed [AW-1:0] v);
        logic [32:0] res;
        if (v > SMAX) begin
            res = {1'b1, MAX32};
        end else if (v < SMIN) begin
            res = {1'b1, MIN32};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    logic adv;
    logic in_acc;

    // Matrix words.
    logic [31:0] r_mat [hpt_pkg::WORDS];

    // Issue register and corner counter.
    logic          r_iss_valid;
    hpt_pkg::t_in  r_iss;
    logic [2:0]    r_corner;
    logic          iss_last;
    logic          in_work;

    // Pass stages.
    logic                     r_p1_valid;
    hpt_pkg::t_ctl            r_p1_ctl;
    logic signed [31:0]       r_p1_pt    [3];
    logic signed [31:0]       r_p1_coef  [4][3];
    logic signed [31:0]       r_p1_trans [4];
    hpt_pkg::t_ctl            n_p1_ctl;
    logic signed [31:0]       n_p1_pt    [3];
    logic signed [31:0]       n_p1_coef  [4][3];
    logic signed [31:0]       n_p1_trans [4];

    logic                     r_p2_valid;
    hpt_pkg::t_ctl            r_p2_ctl;
    logic signed [63:0]       r_p2_prod  [4][3];
    logic signed [31:0]       r_p2_trans [4];

    logic                     r_p3_valid;
    hpt_pkg::t_ctl            r_p3_ctl;
    logic signed [AW-1:0]     r_p3_acc   [4];

    hpt_pkg::t_side           r_p4_side;
    hpt_pkg::t_side           n_p4_side;
    logic [DW-1:0]            r_p4_dvd   [3];
    logic [DW-1:0]            n_p4_dvd   [3];
    logic [31:0]              r_p4_dvs;
    logic [31:0]              n_p4_dvs;
    logic [DW-1:0]            quo        [3];

    hpt_pkg::t_side           r_dly      [NSTG];

    logic                     r_p5_valid;
    hpt_pkg::t_ctl            r_p5_ctl;
    logic [2:0][31:0]         r_p5_val;
    logic                     r_p5_ov;
    logic [2:0][31:0]         n_p5_val;
    logic                     n_p5_ov;

    logic signed [31:0]       r_acc_lo   [3];
    logic signed [31:0]       r_acc_hi   [3];
    logic                     r_acc_ov;
    logic signed [31:0]       cur_lo     [3];
    logic signed [31:0]       cur_hi     [3];
    logic                     cur_ov;

    logic                     r_out_valid;
    hpt_pkg::t_out            r_out;

    // Handshake: the whole pipeline moves when the output register is free.
    assign adv      = !r_out_valid || !i_stall;
    assign iss_last = (r_iss.action != hpt_pkg::ACT_BOX) || (r_corner == 3'd7);
    assign o_stall  = r_iss_valid && !(adv && iss_last);
    assign in_acc   = i_valid && !o_stall;
    assign in_work  = (i_data.action == hpt_pkg::ACT_POINT)  ||
                      (i_data.action == hpt_pkg::ACT_VECTOR) ||
                      (i_data.action == hpt_pkg::ACT_NORMAL) ||
                      (i_data.action == hpt_pkg::ACT_BOX);

    // Matrix store, identity after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hpt_pkg::WORDS; k++) begin
                r_mat[k] <= (((k & 15) == 0) || ((k & 15) == 5) ||
                             ((k & 15) == 10) || ((k & 15) == 15)) ? ONE32 : '0;
            end
        end else if (in_acc && (i_data.action == hpt_pkg::ACT_LOAD)) begin
            r_mat[i_data.entry_index] <= i_data.entry_value;
        end
    end

    // Issue register: holds a request while its passes go out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
            r_corner    <= '0;
        end else if (in_acc) begin
            r_iss_valid <= in_work;
            r_corner    <= '0;
        end else if (r_iss_valid && adv) begin
            if (iss_last) begin
                r_iss_valid <= 1'b0;
            end else begin
                r_corner <= r_corner + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_iss <= i_data;
        end
    end

    // Pass assembly: pick the corner and the coefficients for the action.
    always_comb begin
        n_p1_pt[0] = r_corner[2] ? r_iss.second_x : r_iss.first_x;
        n_p1_pt[1] = r_corner[1] ? r_iss.second_y : r_iss.first_y;
        n_p1_pt[2] = r_corner[0] ? r_iss.second_z : r_iss.first_z;
        n_p1_ctl.is_box = (r_iss.action == hpt_pkg::ACT_BOX);
        n_p1_ctl.is_div = (r_iss.action == hpt_pkg::ACT_BOX) ||
                          (r_iss.action == hpt_pkg::ACT_POINT);
        n_p1_ctl.first  = (r_corner == 3'd0);
        n_p1_ctl.last   = iss_last;
        for (int i = 0; i < 4; i++) begin
            n_p1_trans[i] = '0;
            for (int j = 0; j < 3; j++) begin
                n_p1_coef[i][j] = '0;
            end
        end
        case (r_iss.action)
            hpt_pkg::ACT_POINT, hpt_pkg::ACT_BOX: begin
                for (int i = 0; i < 4; i++) begin
                    n_p1_trans[i] = r_mat[5'(4 * i + 3)];
                    for (int j = 0; j < 3; j++) begin
                        n_p1_coef[i][j] = r_mat[5'(4 * i + j)];
                    end
                end
            end
            hpt_pkg::ACT_VECTOR: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_p1_coef[i][j] = r_mat[5'(4 * i + j)];
                    end
                end
            end
            hpt_pkg::ACT_NORMAL: begin
                // Transposed upper part of the inverse matrix.
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_p1_coef[i][j] = r_mat[5'(hpt_pkg::INVERSE_BASE + i + 4 * j)];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= r_iss_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    // Stage 1 latch, stage 2 products, stage 3 floor shift and sums.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_ctl <= n_p1_ctl;
            r_p2_ctl <= r_p1_ctl;
            r_p3_ctl <= r_p2_ctl;
            for (int i = 0; i < 3; i++) begin
                r_p1_pt[i] <= n_p1_pt[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_p1_trans[i] <= n_p1_trans[i];
                r_p2_trans[i] <= r_p1_trans[i];
                for (int j = 0; j < 3; j++) begin
                    r_p1_coef[i][j] <= n_p1_coef[i][j];
                    r_p2_prod[i][j] <= r_p1_pt[j] * r_p1_coef[i][j];
                end
                r_p3_acc[i] <= AW'(r_p2_prod[i][0] >>> FRACTION_BITS) +
                               AW'(r_p2_prod[i][1] >>> FRACTION_BITS) +
                               AW'(r_p2_prod[i][2] >>> FRACTION_BITS) +
                               AW'(r_p2_trans[i]);
            end
        end
    end

    // Stage 4: saturate, test w and set up the division.
    always_comb begin
        logic [32:0] sw;
        logic [32:0] sn;
        logic        w_one;
        sw    = sat32(r_p3_acc[3]);
        w_one = (r_p3_acc[3] == ONE);
        n_p4_side.vld     = r_p3_valid;
        n_p4_side.ctl     = r_p3_ctl;
        n_p4_side.use_div = 1'b0;
        n_p4_side.ov      = 1'b0;
        n_p4_dvs          = abs32(sw[31:0]);
        for (int i = 0; i < 3; i++) begin
            sn = sat32(r_p3_acc[i]);
            n_p4_side.val[i] = sn[31:0];
            n_p4_side.neg[i] = sn[31] ^ sw[31];
            n_p4_dvd[i]      = {abs32(sn[31:0]), {FRACTION_BITS{1'b0}}};
            n_p4_side.ov     = n_p4_side.ov | sn[32];
            if (r_p3_ctl.is_div && !w_one && (sw[31:0] == '0)) begin
                // Zero w: the sign of the value picks the limit.
                if (sn[31]) begin
                    n_p4_side.val[i] = MIN32;
                end else if (sn[31:0] != '0) begin
                    n_p4_side.val[i] = MAX32;
                end
            end
        end
        if (r_p3_ctl.is_div && !w_one) begin
            n_p4_side.ov = n_p4_side.ov | sw[32] | (sw[31:0] == '0);
            n_p4_side.use_div = (sw[31:0] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_side <= '0;
        end else if (adv) begin
            r_p4_side <= n_p4_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_dvs <= n_p4_dvs;
            for (int i = 0; i < 3; i++) begin
                r_p4_dvd[i] <= n_p4_dvd[i];
            end
        end
    end

    // Three divider lanes, one per axis.
    for (genvar i = 0; i < 3; i++) begin : g_div
        hpt_divider #(
            .DW  (DW),
            .BPS (hpt_pkg::DIV_BITS)
        ) u_div (
            .i_clk      (i_clk),
            .i_en       (adv),
            .i_dividend (r_p4_dvd[i]),
            .i_divisor  (r_p4_dvs),
            .o_quotient (quo[i])
        );
    end

    // Sideband delay line matching the divider depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_dly[k] <= '0;
            end
        end else if (adv) begin
            r_dly[0] <= r_p4_side;
            for (int k = 1; k < NSTG; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // Stage 5: sign and saturate the quotients.
    always_comb begin
        n_p5_ov = r_dly[NSTG-1].ov;
        for (int i = 0; i < 3; i++) begin
            n_p5_val[i] = r_dly[NSTG-1].val[i];
            if (r_dly[NSTG-1].use_div) begin
                if (!r_dly[NSTG-1].neg[i]) begin
                    if (quo[i] > DW'(MAX32)) begin
                        n_p5_val[i] = MAX32;
                        n_p5_ov     = 1'b1;
                    end else begin
                        n_p5_val[i] = quo[i][31:0];
                    end
                end else begin
                    if (quo[i] > DW'(MIN32)) begin
                        n_p5_val[i] = MIN32;
                        n_p5_ov     = 1'b1;
                    end else begin
                        n_p5_val[i] = 32'(-quo[i][31:0]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (adv) begin
            r_p5_valid <= r_dly[NSTG-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5_ctl <= r_dly[NSTG-1].ctl;
            r_p5_val <= n_p5_val;
            r_p5_ov  <= n_p5_ov;
        end
    end

    // Box reduction: running minimum, maximum and overflow.
    always_comb begin
        cur_ov = r_p5_ov | (!r_p5_ctl.first && r_acc_ov);
        for (int i = 0; i < 3; i++) begin
            cur_lo[i] = r_p5_val[i];
            cur_hi[i] = r_p5_val[i];
            if (!r_p5_ctl.first) begin
                if (r_acc_lo[i] < signed'(r_p5_val[i])) begin
                    cur_lo[i] = r_acc_lo[i];
                end
                if (r_acc_hi[i] > signed'(r_p5_val[i])) begin
                    cur_hi[i] = r_acc_hi[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p5_valid && !r_p5_ctl.last) begin
            r_acc_ov <= cur_ov;
            for (int i = 0; i < 3; i++) begin
                r_acc_lo[i] <= cur_lo[i];
                r_acc_hi[i] <= cur_hi[i];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p5_valid && r_p5_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p5_valid && r_p5_ctl.last) begin
            r_out.lo_x     <= cur_lo[0];
            r_out.lo_y     <= cur_lo[1];
            r_out.lo_z     <= cur_lo[2];
            r_out.hi_x     <= r_p5_ctl.is_box ? cur_hi[0] : '0;
            r_out.hi_y     <= r_p5_ctl.is_box ? cur_hi[1] : '0;
            r_out.hi_z     <= r_p5_ctl.is_box ? cur_hi[2] : '0;
            r_out.overflow <= cur_ov;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: hdl/hpt_checker.sv
// Port-level checks for the homogeneous point transform core.
// Depends on hpt_pkg; bound to the top level at the end of this file.
module hpt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input hpt_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input hpt_pkg::t_out o_data
);

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // No result right after reset.
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // The input is open right after reset.
    a_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // A stalled request stays and does not change.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("stalled request changed");

    // Handshake outputs are always known, and so is a shown result.
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall}) && (!o_valid || !$isunknown(o_data)))
        else $error("unknown value on the outputs");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (.*);

FILE: sim/tb.sv
// Testbench for the homogeneous point transform core: random and directed requests
// checked against a behavioral predictor. Depends on hpt_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam int LATENCY = 7 + (32 + FB) / 2;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    hpt_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    hpt_pkg::t_out o_data;

    homogeneous_point_transform_core #(.FRACTION_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state and bookkeeping.
    logic signed [31:0] matrix_words[hpt_pkg::WORDS];
    hpt_pkg::t_in  pending_requests[$];
    hpt_pkg::t_out expected_results[$];
    int    error_count = 0;
    int    result_count = 0;
    int    box_count = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_cycles = 0;
    logic  long_hold = 1'b0;

    function automatic longint sat_val(longint v, ref bit ov);
        if (v > MAXV) begin
            ov = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            ov = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // Product of two words, exact, then floor shift.
    function automatic longint fixed_mul(longint a, longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint dot_three(longint v[3], int base, int stride);
        return fixed_mul(v[0], matrix_words[base]) +
               fixed_mul(v[1], matrix_words[base + stride]) +
               fixed_mul(v[2], matrix_words[base + 2 * stride]);
    endfunction

    // Full homogeneous product with division by w.
    function automatic void project_point(longint p[3], ref longint r[3], ref bit ov);
        longint acc[4];
        longint w, n;
        for (int i = 0; i < 4; i++)
            acc[i] = dot_three(p, i * 4, 1) + longint'(matrix_words[i * 4 + 3]);
        if (acc[3] == (64'sd1 << FB)) begin
            for (int i = 0; i < 3; i++) r[i] = sat_val(acc[i], ov);
            return;
        end
        w = sat_val(acc[3], ov);
        for (int i = 0; i < 3; i++) begin
            n = sat_val(acc[i], ov);
            if (w == 0) begin
                ov = 1'b1;
                r[i] = n > 0 ? MAXV : (n < 0 ? MINV : 0);
            end else begin
                r[i] = sat_val((n * (64'sd1 << FB)) / w, ov);
            end
        end
    endfunction

    // Apply one accepted request to the predictor.
    function automatic void predict_transform(hpt_pkg::t_in req);
        longint a[3], b[3], lo[3], hi[3], p[3], r[3];
        bit ov;
        hpt_pkg::t_out res;
        ov = 1'b0;
        if (req.action == hpt_pkg::ACT_LOAD) begin
            matrix_words[req.entry_index] = req.entry_value;
            return;
        end
        if (req.action > hpt_pkg::ACT_BOX) return;
        a = '{req.first_x, req.first_y, req.first_z};
        b = '{req.second_x, req.second_y, req.second_z};
        hi = '{0, 0, 0};
        lo = '{0, 0, 0};
        case (req.action)
            hpt_pkg::ACT_POINT: begin
                project_point(a, lo, ov);
            end
            hpt_pkg::ACT_VECTOR: begin
                for (int i = 0; i < 3; i++) lo[i] = sat_val(dot_three(a, i * 4, 1), ov);
            end
            hpt_pkg::ACT_NORMAL: begin
                for (int i = 0; i < 3; i++)
                    lo[i] = sat_val(dot_three(a, hpt_pkg::INVERSE_BASE + i, 4), ov);
            end
            default: begin
                for (int c = 0; c < 8; c++) begin
                    p[0] = c[2] ? b[0] : a[0];
                    p[1] = c[1] ? b[1] : a[1];
                    p[2] = c[0] ? b[2] : a[2];
                    project_point(p, r, ov);
                    for (int i = 0; i < 3; i++) begin
                        if (c == 0 || r[i] < lo[i]) lo[i] = r[i];
                        if (c == 0 || r[i] > hi[i]) hi[i] = r[i];
                    end
                end
            end
        endcase
        res.lo_x = 32'(lo[0]); res.lo_y = 32'(lo[1]); res.lo_z = 32'(lo[2]);
        res.hi_x = 32'(hi[0]); res.hi_y = 32'(hi[1]); res.hi_z = 32'(hi[2]);
        res.overflow = ov;
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: bursts of requests with random gaps; holds payload while stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_transform(i_data);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_data <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with short random hold-offs and the long one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold) begin
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case ($urandom_range(3, 0))
                0: i_stall <= 1'b1;
                1: i_stall <= ($urandom_range(7, 0) == 0);
                default: i_stall <= 1'b0;
            endcase
            if ($urandom_range(600, 0) == 0) hold_cycles <= $urandom_range(120, 60);
        end
    end

    // One long receiver hold-off while the sender keeps offering requests.
    initial begin
        wait (i_rst_n);
        wait (pending_requests.size() > 0 && pending_requests.size() < 1500);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        hpt_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result lo_x", o_data.lo_x, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_data.lo_x !== want.lo_x) report_mismatch("lo_x", o_data.lo_x, want.lo_x);
                if (o_data.lo_y !== want.lo_y) report_mismatch("lo_y", o_data.lo_y, want.lo_y);
                if (o_data.lo_z !== want.lo_z) report_mismatch("lo_z", o_data.lo_z, want.lo_z);
                if (o_data.hi_x !== want.hi_x) report_mismatch("hi_x", o_data.hi_x, want.hi_x);
                if (o_data.hi_y !== want.hi_y) report_mismatch("hi_y", o_data.hi_y, want.hi_y);
                if (o_data.hi_z !== want.hi_z) report_mismatch("hi_z", o_data.hi_z, want.hi_z);
                if (o_data.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_data.overflow), 32'(want.overflow));
            end
        end
    end

    // Random coordinate: mostly moderate values, sometimes extremes.
    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(9, 0))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return 0;
            default: return $signed($urandom_range(32'h00c0_0000, 0)) - 32'sh0060_0000;
        endcase
    endfunction

    // Random matrix word: near identity scale, with occasional wide values.
    function automatic logic signed [31:0] random_word();
        case ($urandom_range(7, 0))
            0: return $urandom();
            1: return 0;
            2: return ONE;
            default: return $signed($urandom_range(32'h0004_0000, 0)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic queue_request(logic [2:0] act, logic [4:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] ax, logic signed [31:0] ay,
                                 logic signed [31:0] az, logic signed [31:0] bx,
                                 logic signed [31:0] by, logic signed [31:0] bz);
        hpt_pkg::t_in req;
        req.action = act;
        req.entry_index = idx;
        req.entry_value = val;
        req.first_x = ax; req.first_y = ay; req.first_z = az;
        req.second_x = bx; req.second_y = by; req.second_z = bz;
        pending_requests.push_back(req);
        if (act == hpt_pkg::ACT_BOX) box_count++;
    endtask

    // Stimulus: directed corner cases, then random matrices and transforms.
    initial begin
        logic [2:0] act;
        for (int i = 0; i < hpt_pkg::WORDS; i++)
            matrix_words[i] = (i % 16 == 0 || i % 16 == 5 || i % 16 == 10 || i % 16 == 15)
                              ? ONE : 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity transforms at the field extremes, then each action.
        queue_request(hpt_pkg::ACT_POINT, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_VECTOR, 31, 32'shffffffff, 32'sh80000000, 32'sh7fffffff,
                      ONE, -1, -1, -1);
        queue_request(hpt_pkg::ACT_NORMAL, 0, 0, ONE, -ONE, 3, 0, 0, 0);
        queue_request(hpt_pkg::ACT_BOX, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE);
        // Reversed box.
        queue_request(hpt_pkg::ACT_BOX, 0, 0, ONE, ONE, ONE, -ONE, 0, -ONE);
        // Unused actions are dropped.
        queue_request(3'd5, 0, 0, ONE, ONE, ONE, 0, 0, 0);
        queue_request(3'd7, 31, -1, -1, -1, -1, -1, -1, -1);
        // Zero w: bottom row all zero gives positive, negative and zero values.
        queue_request(hpt_pkg::ACT_LOAD, 15, 0, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_POINT, 0, 0, ONE, -ONE, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_BOX, 0, 0, -ONE, 0, ONE, ONE, ONE, ONE);
        // w of two: real division.
        queue_request(hpt_pkg::ACT_LOAD, 15, 2 * ONE, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_POINT, 0, 0, 3 * ONE, -5, 32'sh7fffffff, 0, 0, 0);
        // Saturating scale and translation.
        queue_request(hpt_pkg::ACT_LOAD, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_LOAD, 3, 32'sh80000000, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_LOAD, 15, ONE, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_POINT, 0, 0, 32'sh7fffffff, 1, 1, 0, 0, 0);
        queue_request(hpt_pkg::ACT_VECTOR, 0, 0, 32'sh80000000, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_LOAD, 17, 32'sh80000000, 0, 0, 0, 0, 0, 0);
        queue_request(hpt_pkg::ACT_NORMAL, 0, 0, ONE, 32'sh80000000, 0, 0, 0, 0);

        // Random part: matrix reloads mixed with transforms.
        for (int n = 0; n < 1830; n++) begin
            act = $urandom_range(99, 0) < 12 ? hpt_pkg::ACT_LOAD : 3'($urandom_range(4, 1));
            if ($urandom_range(99, 0) == 0) act = 3'($urandom_range(7, 5));
            // Sometimes the bottom row gets a projective shape.
            if (act == hpt_pkg::ACT_LOAD && $urandom_range(3, 0) == 0)
                queue_request(hpt_pkg::ACT_LOAD, 5'($urandom_range(15, 12)),
                              $urandom_range(1, 0) ? 0 : random_word(), 0, 0, 0, 0, 0, 0);
            else if (act == hpt_pkg::ACT_LOAD)
                queue_request(hpt_pkg::ACT_LOAD, 5'($urandom()), random_word(),
                              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom());
            else
                queue_request(act, 5'($urandom()), $urandom(), random_coord(), random_coord(),
                              random_coord(), random_coord(), random_coord(), random_coord());
        end

        wait (pending_requests.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("covered %0d results, %0d of them boxes, over reloaded matrices",
                 result_count, box_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("homogeneous_point_transform_core: match");
        end else begin
            $display("errors: %0d, outstanding: %0d", error_count, expected_results.size());
            $display("homogeneous_point_transform_core: mismatch");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #400000;
        $display("timeout with %0d requests and %0d results outstanding",
                 pending_requests.size(), expected_results.size());
        $display("homogeneous_point_transform_core: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hdl/hpt_pkg.sv
hdl/hpt_divider.sv
hdl/homogeneous_point_transform_core.sv
hdl/hpt_checker.sv
sim/tb.sv
